// File: sv/qte_pkg.sv
package qte_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DUP_ADDR,
    ST_DUP_CMP,
    ST_EMIT_RD,
    ST_EMIT_WR,
    ST_SUM
  } state_t;

  localparam logic KIND_TERM    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_EMPTY    = 2'd1;
  localparam logic [1:0] STAT_OVERFLOW = 2'd2;

  localparam int NUM_STOP = 33;

  // Each entry holds the length in the top three bits and the text with the
  // first character in the lowest byte, zero padded.
  localparam logic [42:0] STOP_WORDS [NUM_STOP] = '{
    {3'd1, 40'h0000000061}, {3'd2, 40'h0000006e61}, {3'd3, 40'h0000646e61},
    {3'd3, 40'h0000657261}, {3'd2, 40'h0000007461}, {3'd2, 40'h0000006562},
    {3'd2, 40'h0000007962}, {3'd2, 40'h0000006f64}, {3'd4, 40'h0073656f64},
    {3'd3, 40'h0000726f66}, {3'd4, 40'h006d6f7266}, {3'd3, 40'h0000776f68},
    {3'd1, 40'h0000000069}, {3'd2, 40'h0000006e69}, {3'd2, 40'h0000007369},
    {3'd2, 40'h0000007469}, {3'd2, 40'h000000666f}, {3'd2, 40'h0000006e6f},
    {3'd2, 40'h000000726f}, {3'd4, 40'h0074616874}, {3'd3, 40'h0000656874},
    {3'd4, 40'h0073696874}, {3'd2, 40'h0000006f74}, {3'd3, 40'h0000736177},
    {3'd2, 40'h0000006577}, {3'd4, 40'h0074616877}, {3'd4, 40'h006e656877},
    {3'd5, 40'h6572656877}, {3'd5, 40'h6863696877}, {3'd3, 40'h00006f6877},
    {3'd3, 40'h0000796877}, {3'd4, 40'h0068746977}, {3'd3, 40'h0000756f79}
  };

  typedef struct packed {
    logic take;
    logic clr_len;
    logic set_ovf;
    logic dup_init;
    logic next_slot;
    logic next_word;
    logic emit_init;
    logic emit;
    logic commit;
    logic sum;
  } qte_cmd_t;

  typedef struct packed {
    logic byte_term;
    logic eoq;
    logic ovf;
    logic len_zero;
    logic stop;
    logic slot_done;
    logic cmp_eq;
    logic last_word;
    logic count_full;
    logic out_free;
  } qte_sts_t;

  function automatic logic is_term_byte(logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a) ||
           (b >= 8'h30 && b <= 8'h39) || b[7];
  endfunction

  function automatic logic [7:0] fold_byte(logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5a) ? b + 8'h20 : b;
  endfunction

  function automatic logic is_stop_word(logic [2:0] len, logic [39:0] txt);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < NUM_STOP; i++) begin
      hit = hit | ((STOP_WORDS[i][42:40] == len) && (STOP_WORDS[i][39:0] == txt));
    end
    return hit;
  endfunction

endpackage

// File: sv/query_term_extractor.sv
// Bytes inside a term flow back to back; the output register never stalls them.
// A term end runs the check state, then address and compare per stored term
// compared (per word when lengths match); a new term runs them once more to end
// the search, read and write per 8-byte word, and the summary, plus output stalls.
// Reset (rst, synchronous, active high) clears the controller, term length, term
// count, error flag and output valid; the term RAMs keep undefined contents.
module query_term_extractor #(
  parameter int MAX_TERMS  = 32,
  parameter int TERM_BYTES = 96
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] query_byte
  input  logic        s_axis_tlast,  // end_of_query
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [4:0] term_index, [68:5] term_word, [72:69] word_bytes,
  // [78:73] term_count, [80:79] status, [87:81] zero
  output logic [87:0] m_axis_tdata,
  output logic        m_axis_tuser,  // [0] kind
  output logic        m_axis_tlast   // last
);

  qte_pkg::qte_cmd_t cmd;
  qte_pkg::qte_sts_t sts;

  logic [4:0]  out_index;
  logic [63:0] out_word;
  logic [3:0]  out_bytes;
  logic [5:0]  out_count;
  logic [1:0]  out_status;

  qte_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_last  (s_axis_tlast),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  qte_datapath #(.MAX_TERMS(MAX_TERMS), .TERM_BYTES(TERM_BYTES)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_byte    (s_axis_tdata),
    .in_last    (s_axis_tlast),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_kind   (m_axis_tuser),
    .out_index  (out_index),
    .out_word   (out_word),
    .out_bytes  (out_bytes),
    .out_last   (m_axis_tlast),
    .out_count  (out_count),
    .out_status (out_status)
  );

  assign m_axis_tdata = {7'd0, out_status, out_count, out_bytes, out_word, out_index};

endmodule

// File: sv/qte_ram.sv
module qte_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/qte_ctrl.sv
module qte_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_ready,
  input  qte_pkg::qte_sts_t sts,
  output qte_pkg::qte_cmd_t cmd
);

  qte_pkg::state_t state, state_next;
  qte_pkg::state_t after_term;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= qte_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = 1'b0;
    after_term = sts.eoq ? qte_pkg::ST_SUM : qte_pkg::ST_IDLE;
    unique case (state)
      qte_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          priority if (sts.ovf) begin
            state_next = in_last ? qte_pkg::ST_SUM : qte_pkg::ST_IDLE;
          end else if (sts.byte_term && !in_last) begin
            state_next = qte_pkg::ST_IDLE;
          end else begin
            state_next = qte_pkg::ST_CHECK;
          end
        end
      end
      qte_pkg::ST_CHECK: begin
        if (sts.len_zero || sts.ovf || sts.stop) begin
          cmd.clr_len = 1'b1;
          state_next  = after_term;
        end else begin
          cmd.dup_init = 1'b1;
          state_next   = qte_pkg::ST_DUP_ADDR;
        end
      end
      qte_pkg::ST_DUP_ADDR: begin
        state_next = qte_pkg::ST_DUP_CMP;
      end
      qte_pkg::ST_DUP_CMP: begin
        priority if (sts.slot_done) begin
          if (sts.count_full) begin
            cmd.set_ovf = 1'b1;
            cmd.clr_len = 1'b1;
            state_next  = after_term;
          end else begin
            cmd.emit_init = 1'b1;
            state_next    = qte_pkg::ST_EMIT_RD;
          end
        end else if (!sts.cmp_eq) begin
          cmd.next_slot = 1'b1;
          state_next    = qte_pkg::ST_DUP_ADDR;
        end else if (sts.last_word) begin
          cmd.clr_len = 1'b1;
          state_next  = after_term;
        end else begin
          cmd.next_word = 1'b1;
          state_next    = qte_pkg::ST_DUP_ADDR;
        end
      end
      qte_pkg::ST_EMIT_RD: begin
        state_next = qte_pkg::ST_EMIT_WR;
      end
      qte_pkg::ST_EMIT_WR: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.last_word) begin
            cmd.commit  = 1'b1;
            cmd.clr_len = 1'b1;
            state_next  = after_term;
          end else begin
            cmd.next_word = 1'b1;
            state_next    = qte_pkg::ST_EMIT_RD;
          end
        end
      end
      qte_pkg::ST_SUM: begin
        if (sts.out_free) begin
          cmd.sum    = 1'b1;
          state_next = qte_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = qte_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: sv/qte_datapath.sv
module qte_datapath #(
  parameter int MAX_TERMS  = 32,
  parameter int TERM_BYTES = 96
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  input  qte_pkg::qte_cmd_t cmd,
  output qte_pkg::qte_sts_t sts,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_kind,
  output logic [4:0]        out_index,
  output logic [63:0]       out_word,
  output logic [3:0]        out_bytes,
  output logic              out_last,
  output logic [5:0]        out_count,
  output logic [1:0]        out_status
);

  localparam int LEN_W = $clog2(TERM_BYTES);
  localparam int CNT_W = $clog2(MAX_TERMS + 1);
  localparam int SL_W  = $clog2(MAX_TERMS);
  localparam int WPT   = (TERM_BYTES + 7) / 8;
  localparam int WI_W  = $clog2(WPT);

  logic [LEN_W-1:0] len;
  logic [63:0]      asm_word;
  logic             ovf;
  logic             eoq;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] slot;
  logic [WI_W-1:0]  widx;

  logic [7:0]       fb;
  logic             byte_term;
  logic             too_long;
  logic             append;
  logic [63:0]      asm_new;
  logic [63:0]      cur_rdata;
  logic [63:0]      store_rdata;
  logic [LEN_W-1:0] len_rdata;
  logic [31:0]      count_ext;
  logic [31:0]      count_inc;
  logic             last_word;

  assign fb        = qte_pkg::fold_byte(in_byte);
  assign byte_term = qte_pkg::is_term_byte(in_byte);
  assign too_long  = (32'(len) + 32'd1) >= 32'(TERM_BYTES);
  assign append    = cmd.take && !ovf && byte_term && !too_long;
  assign asm_new   = asm_word | (64'(fb) << {len[2:0], 3'b000});
  assign count_ext = 32'(count);
  assign count_inc = count_ext + 32'd1;
  assign last_word = widx == WI_W'((len - LEN_W'(1)) >> 3);

  qte_ram #(.WIDTH(64), .DEPTH(WPT)) u_cur (
    .clk   (clk),
    .we    (append),
    .waddr (WI_W'(len >> 3)),
    .wdata (asm_new),
    .raddr (widx),
    .rdata (cur_rdata)
  );

  qte_ram #(.WIDTH(64), .DEPTH(MAX_TERMS << WI_W)) u_store (
    .clk   (clk),
    .we    (cmd.emit),
    .waddr ({count[SL_W-1:0], widx}),
    .wdata (cur_rdata),
    .raddr ({slot[SL_W-1:0], widx}),
    .rdata (store_rdata)
  );

  qte_ram #(.WIDTH(LEN_W), .DEPTH(MAX_TERMS)) u_lens (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (count[SL_W-1:0]),
    .wdata (len),
    .raddr (slot[SL_W-1:0]),
    .rdata (len_rdata)
  );

  always_comb begin
    sts.byte_term  = byte_term;
    sts.eoq        = eoq;
    sts.ovf        = ovf;
    sts.len_zero   = len == '0;
    sts.stop       = (32'(len) <= 32'd5) && qte_pkg::is_stop_word(len[2:0], asm_word[39:0]);
    sts.slot_done  = slot >= count;
    sts.cmp_eq     = (len_rdata == len) && (store_rdata == cur_rdata);
    sts.last_word  = last_word;
    sts.count_full = 32'(count) >= 32'(MAX_TERMS);
    sts.out_free   = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len       <= '0;
      asm_word  <= '0;
      ovf       <= 1'b0;
      eoq       <= 1'b0;
      count     <= '0;
      slot      <= '0;
      widx      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.take) begin
        eoq <= in_last;
        if (!ovf && byte_term) begin
          if (too_long) begin
            ovf      <= 1'b1;
            len      <= '0;
            asm_word <= '0;
          end else begin
            len      <= len + LEN_W'(1);
            asm_word <= (len[2:0] == 3'd7) ? 64'd0 : asm_new;
          end
        end
      end
      if (cmd.clr_len) begin
        len      <= '0;
        asm_word <= '0;
      end
      if (cmd.set_ovf) begin
        ovf <= 1'b1;
      end
      if (cmd.dup_init || cmd.next_slot) begin
        slot <= cmd.dup_init ? '0 : slot + CNT_W'(1);
        widx <= '0;
      end
      if (cmd.next_word) begin
        widx <= widx + WI_W'(1);
      end
      if (cmd.emit_init) begin
        widx <= '0;
      end
      if (cmd.emit) begin
        out_valid  <= 1'b1;
        out_kind   <= qte_pkg::KIND_TERM;
        out_index  <= count_ext[4:0];
        out_word   <= cur_rdata;
        out_bytes  <= (last_word && len[2:0] != 3'd0) ? {1'b0, len[2:0]} : 4'd8;
        out_last   <= last_word && !eoq;
        out_count  <= count_inc[5:0];
        out_status <= qte_pkg::STAT_OK;
      end
      if (cmd.commit) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.sum) begin
        out_valid  <= 1'b1;
        out_kind   <= qte_pkg::KIND_SUMMARY;
        out_index  <= 5'd0;
        out_word   <= 64'd0;
        out_bytes  <= 4'd0;
        out_last   <= 1'b1;
        out_count  <= count_ext[5:0];
        out_status <= ovf ? qte_pkg::STAT_OVERFLOW :
                      (count == '0 ? qte_pkg::STAT_EMPTY : qte_pkg::STAT_OK);
        count      <= '0;
        ovf        <= 1'b0;
        len        <= '0;
        asm_word   <= '0;
      end
    end
  end

endmodule

// File: sv/qte_checker.sv
module qte_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [87:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // A beat that is not taken stays offered.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output beat dropped while stalled");

  // A summary carries no term bytes and closes the run of its input byte.
  a_summary: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[72:69] == 4'd0 && m_axis_tlast)
    else $error("malformed summary beat");

  // A term word holds one to eight bytes, status ok, and counts its own term.
  a_word: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |->
      m_axis_tdata[72:69] != 4'd0 && m_axis_tdata[72:69] <= 4'd8 &&
      m_axis_tdata[80:79] == 2'd0 && m_axis_tdata[78:73] != 6'd0)
    else $error("malformed term word beat");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[80:79] != 2'd3 && m_axis_tdata[87:81] == 7'd0)
    else $error("bad status or padding");

endmodule

bind query_term_extractor qte_checker u_qte_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// File: verif/query_term_checker.sv
`timescale 1ns / 1ps
module query_term_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [87:0] m_axis_tdata,
  input  logic        m_axis_tuser,
  input  logic        m_axis_tlast,
  output int          error_count,
  output int          pending_words
);

  localparam int MAX_TERMS  = 32;
  localparam int TERM_BYTES = 96;

  typedef struct packed {
    logic        kind;
    logic [4:0]  term_index;
    logic [63:0] term_word;
    logic [3:0]  word_bytes;
    logic        last;
    logic [5:0]  term_count;
    logic [1:0]  status;
  } query_result_t;

  query_result_t expected_words[$];

  logic [7:0] open_term[TERM_BYTES];
  int         open_len;
  logic [7:0] kept_terms[MAX_TERMS][TERM_BYTES];
  int         kept_lens[MAX_TERMS];
  int         kept_count;
  logic       capacity_error;

  assign pending_words = expected_words.size();

  function automatic logic term_is_stop_word();
    logic [39:0] txt;
    txt = '0;
    if (open_len > 5) return 1'b0;
    for (int i = 0; i < open_len; i++) txt[8*i +: 8] = open_term[i];
    return qte_pkg::is_stop_word(open_len[2:0], txt);
  endfunction

  function automatic logic term_already_kept();
    logic same;
    for (int s = 0; s < kept_count; s++) begin
      if (kept_lens[s] == open_len) begin
        same = 1'b1;
        for (int i = 0; i < open_len; i++)
          if (kept_terms[s][i] != open_term[i]) same = 1'b0;
        if (same) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Closes the open term and queues its words if it is new.
  task automatic close_term(inout query_result_t produced[$]);
    query_result_t r;
    int len;
    len = open_len;
    if (len == 0 || capacity_error) begin
      open_len = 0;
      return;
    end
    if (term_is_stop_word() || term_already_kept()) begin
      open_len = 0;
      return;
    end
    if (kept_count >= MAX_TERMS) begin
      capacity_error = 1'b1;
      open_len = 0;
      return;
    end
    for (int i = 0; i < len; i++) kept_terms[kept_count][i] = open_term[i];
    kept_lens[kept_count] = len;
    kept_count++;
    for (int pos = 0; pos < len; pos += 8) begin
      r = '0;
      r.kind = qte_pkg::KIND_TERM;
      r.term_index = 5'(kept_count - 1);
      r.word_bytes = 4'((len - pos < 8) ? len - pos : 8);
      for (int j = 0; j < r.word_bytes; j++) r.term_word[8*j +: 8] = open_term[pos + j];
      r.term_count = 6'(kept_count);
      produced.push_back(r);
    end
    open_len = 0;
  endtask

  task automatic predict_byte(logic [7:0] b, logic eoq);
    query_result_t produced[$];
    query_result_t r;
    if (!capacity_error) begin
      if (qte_pkg::is_term_byte(b)) begin
        if (open_len + 1 >= TERM_BYTES) begin
          capacity_error = 1'b1;
          open_len = 0;
        end else begin
          open_term[open_len] = qte_pkg::fold_byte(b);
          open_len++;
        end
        if (eoq) close_term(produced);
      end else begin
        close_term(produced);
      end
    end
    if (eoq) begin
      r = '0;
      r.kind = qte_pkg::KIND_SUMMARY;
      r.term_count = 6'(kept_count);
      r.status = capacity_error ? qte_pkg::STAT_OVERFLOW :
                 (kept_count == 0 ? qte_pkg::STAT_EMPTY : qte_pkg::STAT_OK);
      produced.push_back(r);
      open_len = 0;
      kept_count = 0;
      capacity_error = 1'b0;
    end
    if (produced.size() > 0) produced[produced.size() - 1].last = 1'b1;
    foreach (produced[i]) expected_words.push_back(produced[i]);
  endtask

  always @(posedge clk) begin
    query_result_t seen, want;
    if (rst) begin
      open_len = 0;
      kept_count = 0;
      capacity_error = 1'b0;
      error_count <= 0;
      expected_words.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen.kind = m_axis_tuser;
        seen.term_index = m_axis_tdata[4:0];
        seen.term_word = m_axis_tdata[68:5];
        seen.word_bytes = m_axis_tdata[72:69];
        seen.term_count = m_axis_tdata[78:73];
        seen.status = m_axis_tdata[80:79];
        seen.last = m_axis_tlast;
        if (expected_words.size() == 0) begin
          if (error_count < 10) $display("unexpected beat %p", seen);
          error_count <= error_count + 1;
        end else begin
          want = expected_words.pop_front();
          if (seen !== want || m_axis_tdata[87:81] !== '0) begin
            if (error_count < 10) $display("mismatch: expected %p, got %p", want, seen);
            error_count <= error_count + 1;
          end
        end
      end
      // Prediction runs after the pop so a same-edge result sees the old queue.
      if (s_axis_tvalid && s_axis_tready) predict_byte(s_axis_tdata, s_axis_tlast);
    end
  end
endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  int          error_count;
  int          pending_words;
  int          cycle_count = 0;
  logic [7:0]  query_bytes[$];
  logic        query_ends[$];

  always #6 clk = ~clk;

  query_term_extractor dut (.*);

  query_term_checker checker_i (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 600000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver stalls a random number of cycles before each result beat.
  initial begin
    int gap;
    @(posedge clk iff !rst);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk iff m_axis_tvalid);
    end
  end

  task automatic add_text(string s, logic eoq);
    for (int i = 0; i < s.len(); i++) begin
      query_bytes.push_back(s[i]);
      query_ends.push_back(eoq && i == s.len() - 1);
    end
  endtask

  function automatic logic [7:0] random_term_byte();
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(8'h61, 8'h7a));
      1: return 8'($urandom_range(8'h41, 8'h5a));
      2: return 8'($urandom_range(8'h30, 8'h39));
      default: return 8'($urandom_range(8'h80, 8'hff));
    endcase
  endfunction

  function automatic logic [7:0] random_separator();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 8'h7f)); while (qte_pkg::is_term_byte(b));
    return b;
  endfunction

  initial begin
    int gap, total, nterms, tlen;
    string long_term;
    // Directed: stop words, duplicates, case folding, empty query, long words, too many terms.
    add_text("The Quick fox AND the fox IS quick.", 1'b1);
    add_text("", 1'b0);
    query_bytes.push_back(8'h00);
    query_ends.push_back(1'b1);
    add_text("where which you abcdefghijklmnopq\xff\x80Z9", 1'b1);
    long_term = "";
    for (int i = 0; i < 96; i++) long_term = {long_term, "k"};
    add_text(long_term, 1'b1);
    for (int i = 0; i < 33; i++) begin
      query_bytes.push_back(8'h41 + 8'(i % 26));
      query_bytes.push_back(8'h30 + 8'(i / 26));
      query_bytes.push_back(8'h20);
      query_ends.push_back(1'b0);
      query_ends.push_back(1'b0);
      query_ends.push_back(i == 32);
    end
    // Random queries: well-formed terms with occasional stop words and repeats.
    total = query_bytes.size();
    while (total < 270) begin
      nterms = $urandom_range(0, 6);
      for (int t = 0; t < nterms; t++) begin
        if ($urandom_range(0, 5) == 0) add_text("the", 1'b0);
        else if ($urandom_range(0, 5) == 0) add_text("ab", 1'b0);
        else begin
          tlen = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 10);
          for (int j = 0; j < tlen; j++) begin
            query_bytes.push_back(random_term_byte());
            query_ends.push_back(1'b0);
          end
        end
        repeat ($urandom_range(1, 2)) begin
          query_bytes.push_back(random_separator());
          query_ends.push_back(1'b0);
        end
      end
      query_bytes.push_back($urandom_range(0, 1) ? random_term_byte() : random_separator());
      query_ends.push_back(1'b1);
      total = query_bytes.size();
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    foreach (query_bytes[i]) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= query_bytes[i];
      s_axis_tlast  <= query_ends[i];
      @(posedge clk iff s_axis_tready);
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk iff pending_words == 0);
    repeat (200) @(posedge clk);
    if (error_count == 0 && pending_words == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// File: filelist.f
sv/qte_pkg.sv
sv/qte_ram.sv
sv/qte_ctrl.sv
sv/qte_datapath.sv
sv/query_term_extractor.sv
sv/qte_checker.sv
verif/query_term_checker.sv
verif/testbench.sv
